[hw/rtl/fbx_pkg.sv]
// Shared types, constants and header byte function for the frame builder.
`timescale 1ns / 1ps

package fbx_pkg;

    // Fixed frame layout.
    localparam int HEADER_BYTES     = 12;
    localparam int HDR_IDX_W        = $clog2(HEADER_BYTES);
    localparam int STATUS_BYTES_DEF = 4;
    localparam int QUEUE_DEPTH      = 2;

    localparam logic [7:0] SYNC_0    = 8'hAA;
    localparam logic [7:0] SYNC_1    = 8'h55;
    localparam logic [7:0] SYNC_2    = 8'hA5;
    localparam logic [7:0] SYNC_3    = 8'h5A;
    localparam logic [7:0] FILL_BYTE = 8'hFF;
    localparam logic [7:0] ZERO_BYTE = 8'h00;

    // Header byte positions.
    localparam logic [HDR_IDX_W-1:0] HP_SYNC_0   = HDR_IDX_W'(0);
    localparam logic [HDR_IDX_W-1:0] HP_SYNC_1   = HDR_IDX_W'(1);
    localparam logic [HDR_IDX_W-1:0] HP_SYNC_2   = HDR_IDX_W'(2);
    localparam logic [HDR_IDX_W-1:0] HP_SYNC_3   = HDR_IDX_W'(3);
    localparam logic [HDR_IDX_W-1:0] HP_STYPE    = HDR_IDX_W'(4);
    localparam logic [HDR_IDX_W-1:0] HP_SNUM_LO  = HDR_IDX_W'(5);
    localparam logic [HDR_IDX_W-1:0] HP_SNUM_HI  = HDR_IDX_W'(6);
    localparam logic [HDR_IDX_W-1:0] HP_KIND     = HDR_IDX_W'(9);
    localparam logic [HDR_IDX_W-1:0] HP_FLEN_LO  = HDR_IDX_W'(10);
    localparam logic [HDR_IDX_W-1:0] HP_FLEN_HI  = HDR_IDX_W'(11);

    // Register indexes on the configuration port.
    typedef enum logic [0:0] {
        REG_NODE_TYPE      = 1'b0,
        REG_STATION_NUMBER = 1'b1
    } t_reg_idx;

    // Station configuration seen by the back end.
    typedef struct packed {
        logic [7:0]  node_type;
        logic [15:0] station_number;
    } t_station;

    // One classified item, as passed from the front end to the back end.
    typedef struct packed {
        logic        open;      // item opens a frame: header and status first
        logic        has;       // payload byte present
        logic        last;      // close the frame with the checksum
        logic [7:0]  data;
        logic [7:0]  kind;
        logic [15:0] flen;      // header length field
        logic [7:0]  seq;
    } t_cmd;

    // Back end emission phase.
    typedef enum logic [3:0] {
        PH_HDR  = 4'b0001,
        PH_STAT = 4'b0010,
        PH_DATA = 4'b0100,
        PH_CHK  = 4'b1000
    } t_phase;

    function automatic logic [7:0] header_byte(
        input logic [HDR_IDX_W-1:0] idx,
        input t_station             stn,
        input logic [7:0]           kind,
        input logic [15:0]          flen
    );
        logic [7:0] b;
        b = ZERO_BYTE;
        unique case (idx)
            HP_SYNC_0:  b = SYNC_0;
            HP_SYNC_1:  b = SYNC_1;
            HP_SYNC_2:  b = SYNC_2;
            HP_SYNC_3:  b = SYNC_3;
            HP_STYPE:   b = stn.node_type;
            HP_SNUM_LO: b = stn.station_number[7:0];
            HP_SNUM_HI: b = stn.station_number[15:8];
            HP_KIND:    b = kind;
            HP_FLEN_LO: b = flen[7:0];
            HP_FLEN_HI: b = flen[15:8];
            default:    b = ZERO_BYTE;
        endcase
        return b;
    endfunction

endpackage

[hw/rtl/fbx_front.sv]
// Front end: accepts input transfers, tracks the open frame and classifies items.
`timescale 1ns / 1ps

module fbx_front #(
    parameter int STATUS_BYTES = fbx_pkg::STATUS_BYTES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [7:0]    i_payload_byte,
    input  logic          i_has_byte,
    input  logic          i_frame_last,
    input  logic [15:0]   i_payload_length,
    input  logic [7:0]    i_frame_kind,
    input  logic          i_queue_full,
    output logic          o_push,
    output fbx_pkg::t_cmd o_cmd
);
    import fbx_pkg::*;

    logic       r_in_frame;
    logic       n_in_frame;
    logic [7:0] r_seq;
    logic [7:0] n_seq;
    logic       accept;
    logic       opening;

    assign o_ready = !i_queue_full;
    assign accept  = i_valid && o_ready;
    assign opening = !r_in_frame;

    // An idle item inside an open frame yields nothing and is dropped here.
    assign o_push = accept && (opening || i_has_byte || i_frame_last);

    always_comb begin
        o_cmd.open = opening;
        o_cmd.has  = i_has_byte;
        o_cmd.last = i_frame_last;
        o_cmd.data = i_payload_byte;
        o_cmd.kind = i_frame_kind;
        o_cmd.flen = i_payload_length + 16'(STATUS_BYTES);
        o_cmd.seq  = r_seq;
    end

    always_comb begin
        n_in_frame = r_in_frame;
        n_seq      = r_seq;
        if (accept) begin
            if (opening) begin
                n_seq = r_seq + 8'd1;
            end
            n_in_frame = !i_frame_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_seq      <= 8'd0;
        end else begin
            r_in_frame <= n_in_frame;
            r_seq      <= n_seq;
        end
    end

endmodule

[hw/rtl/fbx_queue.sv]
// Two-entry command queue between the front end and the back end.
`timescale 1ns / 1ps

module fbx_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  fbx_pkg::t_cmd i_wdata,
    output logic          o_full,
    output logic          o_valid,
    output fbx_pkg::t_cmd o_rdata,
    input  logic          i_pop
);
    import fbx_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_rdata = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[hw/rtl/fbx_back.sv]
// Back end: expands queued commands into frame bytes through an output register.
`timescale 1ns / 1ps

module fbx_back #(
    parameter int STATUS_BYTES = fbx_pkg::STATUS_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fbx_pkg::t_station i_station,
    input  logic              i_cmd_valid,
    input  fbx_pkg::t_cmd     i_cmd,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [7:0]        o_byte,
    output logic              o_run_last,
    output logic              o_frame_end
);
    import fbx_pkg::*;

    localparam int MAX_RUN = (HEADER_BYTES > STATUS_BYTES) ? HEADER_BYTES : STATUS_BYTES;
    localparam int CNT_W   = $clog2(MAX_RUN + 1);

    logic             r_busy;
    t_phase           r_phase;
    logic [CNT_W-1:0] r_cnt;
    logic [7:0]       r_xor;
    logic             r_out_valid;
    logic [7:0]       r_out_byte;
    logic             r_out_last;
    logic             r_out_end;

    t_phase           first_phase;
    t_phase           cur_phase;
    logic [CNT_W-1:0] cur_cnt;
    t_phase           n_phase;
    logic [CNT_W-1:0] n_cnt;
    logic [7:0]       n_xor;
    logic [7:0]       cur_byte;
    logic             done;
    logic             adv;

    always_comb begin
        if (i_cmd.open) begin
            first_phase = PH_HDR;
        end else if (i_cmd.has) begin
            first_phase = PH_DATA;
        end else begin
            first_phase = PH_CHK;
        end
    end

    assign cur_phase = r_busy ? r_phase : first_phase;
    assign cur_cnt   = r_busy ? r_cnt : '0;
    assign adv       = i_cmd_valid && (!r_out_valid || i_ready);
    assign o_pop     = adv && done;

    always_comb begin
        cur_byte = ZERO_BYTE;
        n_phase  = cur_phase;
        n_cnt    = cur_cnt + 1'b1;
        done     = 1'b0;
        unique case (cur_phase)
            PH_HDR: begin
                cur_byte = header_byte(cur_cnt[HDR_IDX_W-1:0], i_station,
                                       i_cmd.kind, i_cmd.flen);
                if (cur_cnt == CNT_W'(HEADER_BYTES - 1)) begin
                    n_phase = PH_STAT;
                    n_cnt   = '0;
                end
            end
            PH_STAT: begin
                cur_byte = (cur_cnt == '0) ? i_cmd.seq : FILL_BYTE;
                if (cur_cnt == CNT_W'(STATUS_BYTES - 1)) begin
                    n_cnt = '0;
                    if (i_cmd.has) begin
                        n_phase = PH_DATA;
                    end else if (i_cmd.last) begin
                        n_phase = PH_CHK;
                    end else begin
                        done = 1'b1;
                    end
                end
            end
            PH_DATA: begin
                cur_byte = i_cmd.data;
                n_cnt    = '0;
                if (i_cmd.last) begin
                    n_phase = PH_CHK;
                end else begin
                    done = 1'b1;
                end
            end
            PH_CHK: begin
                cur_byte = r_xor;
                n_cnt    = '0;
                done     = 1'b1;
            end
            default: begin
                n_cnt = '0;
                done  = 1'b1;
            end
        endcase
    end

    // The checksum covers the header from its first byte and clears after use.
    always_comb begin
        if (cur_phase == PH_CHK) begin
            n_xor = 8'd0;
        end else if (cur_phase == PH_HDR && cur_cnt == '0) begin
            n_xor = cur_byte;
        end else begin
            n_xor = r_xor ^ cur_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_phase     <= PH_HDR;
            r_cnt       <= '0;
            r_xor       <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (adv) begin
                r_busy      <= !done;
                r_phase     <= n_phase;
                r_cnt       <= n_cnt;
                r_xor       <= n_xor;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_byte <= cur_byte;
            r_out_last <= done;
            r_out_end  <= (cur_phase == PH_CHK);
        end
    end

    assign o_valid     = r_out_valid;
    assign o_byte      = r_out_byte;
    assign o_run_last  = r_out_last;
    assign o_frame_end = r_out_end;

`ifndef SYNTHESIS
    a_chk_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_end |-> r_out_last)
        else $error("checksum byte not marked as end of run");

    a_busy_holds_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> i_cmd_valid)
        else $error("command left the queue while still being expanded");

    a_chk_only_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && cur_phase == PH_CHK |-> i_cmd.last)
        else $error("checksum emitted for a command that does not close a frame");

    a_stat_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && r_phase == PH_STAT |-> r_cnt < CNT_W'(STATUS_BYTES))
        else $error("status byte counter out of range");
`endif

endmodule

[hw/rtl/frame_builder_xor_checksum.sv]
// Top level of the frame builder with XOR checksum: configuration and block wiring.
`timescale 1ns / 1ps

// Channel   Direction  Width   Contents
// s_*       in         32+1+1  payload transfers; tuser = has_byte, tlast = frame_last
// m_*       out        8+1+1   frame bytes; tuser = frame_end, tlast = run_last
// apb       in/out     32      node type at 0x0, station_number at 0x4
//
// Inside an open frame a payload transfer yields its byte, plus the checksum if last.
// The transfer that opens a frame produces 12 + STATUS_BYTES header and status bytes
// (plus its payload byte and checksum, if any), one byte a cycle unless the output
// stalls, through the single byte-wide output register of the back end. The command
// being expanded stays at the head of the two-entry queue, so the front end takes one
// more byte-carrying transfer during the burst, then stalls until the burst has drained.
// Reset is synchronous and active low; it closes any open frame, clears the sequence
// and the checksum and empties the queue. Either stream side may stall at any time.

module frame_builder_xor_checksum #(
    parameter int STATUS_BYTES = fbx_pkg::STATUS_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [7:0] payload_byte, [23:8] payload_length, [31:24] frame_kind
    input  logic [31:0] i_s_tdata,
    // [0] has_byte
    input  logic        i_s_tuser,
    input  logic        i_s_tlast,
    // Output stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [7:0] out_byte
    output logic [7:0]  o_m_tdata,
    // [0] frame_end
    output logic        o_m_tuser,
    output logic        o_m_tlast,
    // Configuration port
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);
    import fbx_pkg::*;

    logic [7:0]  r_node_type;
    logic [15:0] r_station_number;
    t_reg_idx    reg_idx;
    logic        cfg_write;
    t_station    station;

    logic        push;
    t_cmd        push_cmd;
    logic        queue_full;
    logic        head_valid;
    t_cmd        head_cmd;
    logic        pop;

    // Registers are word-spaced; the byte offset within the word is ignored.
    assign reg_idx   = t_reg_idx'(i_paddr[2]);
    assign cfg_write = i_psel && i_penable && i_pwrite && o_pready;
    assign o_pready  = 1'b1;

    always_comb begin
        unique case (reg_idx)
            REG_NODE_TYPE:      o_prdata = {24'd0, r_node_type};
            REG_STATION_NUMBER: o_prdata = {16'd0, r_station_number};
            default:            o_prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_type      <= 8'd0;
            r_station_number <= 16'd0;
        end else if (cfg_write) begin
            unique case (reg_idx)
                REG_NODE_TYPE:      r_node_type      <= i_pwdata[7:0];
                REG_STATION_NUMBER: r_station_number <= i_pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    // The back end reads the station registers as it emits each header, so the user must
    // change them only while the block is idle; the block itself does not enforce this.
    always_comb begin
        station.node_type      = r_node_type;
        station.station_number = r_station_number;
    end

    fbx_front #(
        .STATUS_BYTES (STATUS_BYTES)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_s_tvalid),
        .o_ready          (o_s_tready),
        .i_payload_byte   (i_s_tdata[7:0]),
        .i_has_byte       (i_s_tuser),
        .i_frame_last     (i_s_tlast),
        .i_payload_length (i_s_tdata[23:8]),
        .i_frame_kind     (i_s_tdata[31:24]),
        .i_queue_full     (queue_full),
        .o_push           (push),
        .o_cmd            (push_cmd)
    );

    fbx_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (push_cmd),
        .o_full  (queue_full),
        .o_valid (head_valid),
        .o_rdata (head_cmd),
        .i_pop   (pop)
    );

    fbx_back #(
        .STATUS_BYTES (STATUS_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_station   (station),
        .i_cmd_valid (head_valid),
        .i_cmd       (head_cmd),
        .o_pop       (pop),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_byte      (o_m_tdata),
        .o_run_last  (o_m_tlast),
        .o_frame_end (o_m_tuser)
    );

endmodule
